// ===== rtl/sbce_pkg.sv =====
// shared constants and types for the switch bank change event block
package sbce_pkg;

  localparam int SWITCH_BYTES = 16;
  localparam int BYTE_W       = 8;
  localparam int ORD_W        = 3;
  localparam int NUM_W        = 7;
  localparam int POS_W        = (SWITCH_BYTES > 1) ? $clog2(SWITCH_BYTES) : 1;

  typedef logic [BYTE_W-1:0] sbce_byte_t;
  typedef logic [POS_W-1:0]  sbce_pos_t;

  // changed byte handed from the lookup stage to the event serializer
  typedef struct packed {
    sbce_byte_t diff;
    sbce_byte_t now;
    sbce_pos_t  pos;
  } sbce_chg_t;

endpackage

// ===== rtl/sbce_in_if.sv =====
// input channel: one scanned byte per item
interface sbce_in_if;
  logic                       valid;
  logic                       ready;
  logic [sbce_pkg::BYTE_W-1:0] switch_byte;
  logic                       last_in_scan;

  modport source(output valid, output switch_byte, output last_in_scan, input ready);
  modport sink(input valid, input switch_byte, input last_in_scan, output ready);
endinterface

// ===== rtl/sbce_out_if.sv =====
// result channel: one switch change event per item
interface sbce_out_if;
  logic                       valid;
  logic                       ready;
  logic [sbce_pkg::NUM_W-1:0] switch_number;
  logic                       switch_on;
  logic                       last_event;

  modport source(output valid, output switch_number, output switch_on, output last_event,
                 input ready);
  modport sink(input valid, input switch_number, input switch_on, input last_event,
               output ready);
endinterface

// ===== rtl/sbce_ram.sv =====
// generic single write port ram with registered read
module sbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sbce_lookup.sv =====
// position counter, previous scan store and byte compare
module sbce_lookup (
  input  logic               clk,
  input  logic               rst_n,
  sbce_in_if.sink            in_ch,
  output logic               chg_valid,
  input  logic               chg_ready,
  output sbce_pkg::sbce_chg_t chg
);

  logic                 acc;
  logic                 b_go;
  sbce_pkg::sbce_pos_t  pos_r, pos_nxt;
  logic                 b_valid_r, b_valid_nxt;
  sbce_pkg::sbce_byte_t b_byte_r;
  sbce_pkg::sbce_pos_t  b_pos_r;
  logic                 b_vld_r;
  logic                 fwd_r, fwd_nxt;
  sbce_pkg::sbce_byte_t fwd_data_r;
  logic                 vld_r [sbce_pkg::SWITCH_BYTES];
  sbce_pkg::sbce_byte_t rdata;
  sbce_pkg::sbce_byte_t old_byte;
  sbce_pkg::sbce_byte_t diff;

  // stored bytes of the previous scan
  sbce_ram #(
    .WIDTH(sbce_pkg::BYTE_W),
    .DEPTH(sbce_pkg::SWITCH_BYTES),
    .AW   (sbce_pkg::POS_W)
  ) u_prev (
    .clk  (clk),
    .we   (b_go),
    .waddr(b_pos_r),
    .wdata(b_byte_r),
    .re   (acc),
    .raddr(pos_r),
    .rdata(rdata)
  );

  // compare against the stored byte, forwarding a write made at the read edge
  always_comb begin
    if (fwd_r) begin
      old_byte = fwd_data_r;
    end else if (b_vld_r) begin
      old_byte = rdata;
    end else begin
      old_byte = '0;
    end
    diff = b_byte_r ^ old_byte;
  end

  assign chg_valid = b_valid_r && (diff != '0);
  assign chg       = '{diff: diff, now: b_byte_r, pos: b_pos_r};

  // an unchanged byte leaves at once, a changed one waits for the serializer
  assign b_go        = b_valid_r && ((diff == '0) || chg_ready);
  assign in_ch.ready = !b_valid_r || b_go;
  assign acc         = in_ch.valid && in_ch.ready;

  // next position and stage control
  always_comb begin
    pos_nxt = pos_r;
    if (acc) begin
      if (in_ch.last_in_scan || (pos_r == sbce_pkg::POS_W'(sbce_pkg::SWITCH_BYTES - 1))) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
    b_valid_nxt = acc || (b_valid_r && !b_go);
    fwd_nxt     = acc ? (b_go && (b_pos_r == pos_r)) : (fwd_r && !b_go);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      b_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      b_valid_r <= b_valid_nxt;
      fwd_r     <= fwd_nxt;
    end
  end

  // lookup stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      b_byte_r   <= in_ch.switch_byte;
      b_pos_r    <= pos_r;
      b_vld_r    <= vld_r[pos_r];
      fwd_data_r <= b_byte_r;
    end
  end

  // entry written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sbce_pkg::SWITCH_BYTES; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (b_go) begin
      vld_r[b_pos_r] <= 1'b1;
    end
  end

  // forwarding only ever applies to a byte under lookup
  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> b_valid_r)
    else $error("forward flag set with empty lookup stage");

  // a byte written back with a new byte read at the same entry must be forwarded
  a_fwd_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && b_go && (b_pos_r == pos_r)) |=> fwd_r)
    else $error("missed forward of same entry write");

  // a waiting changed byte stays put
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_go) |=> (b_valid_r && $stable(b_byte_r) && $stable(b_pos_r)))
    else $error("waiting byte changed in lookup stage");

endmodule

// ===== rtl/sbce_emit.sv =====
// serializes the changed bits of one byte into events, bit 7 first
module sbce_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               chg_valid,
  output logic               chg_ready,
  input  sbce_pkg::sbce_chg_t chg,
  sbce_out_if.source         out_ch
);

  sbce_pkg::sbce_byte_t mask_r, mask_nxt;
  sbce_pkg::sbce_byte_t now_r;
  sbce_pkg::sbce_pos_t  pos_r;
  logic                 busy;
  logic                 step;
  logic                 load;
  logic [sbce_pkg::ORD_W-1:0] ord;
  sbce_pkg::sbce_byte_t rest;
  logic [sbce_pkg::POS_W+sbce_pkg::ORD_W-1:0] full_num;
  logic                       out_valid_r, out_valid_nxt;
  logic [sbce_pkg::NUM_W-1:0] num_r;
  logic                       on_r;
  logic                       last_r;

  // first changed switch in shifting order
  always_comb begin
    ord = '0;
    for (int k = sbce_pkg::BYTE_W - 1; k >= 0; k--) begin
      if (mask_r[sbce_pkg::BYTE_W - 1 - k]) begin
        ord = sbce_pkg::ORD_W'(k);
      end
    end
    rest = mask_r;
    rest[3'(sbce_pkg::BYTE_W - 1) - ord] = 1'b0;
    full_num = {pos_r, ord};
  end

  assign busy      = (mask_r != '0);
  assign step      = busy && (!out_valid_r || out_ch.ready);
  assign chg_ready = !busy || (step && (rest == '0));
  assign load      = chg_valid && chg_ready;

  // pending bit mask and output valid
  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = chg.diff;
    end else if (step) begin
      mask_nxt = rest;
    end
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // byte payload
  always_ff @(posedge clk) begin
    if (load) begin
      now_r <= chg.now;
      pos_r <= chg.pos;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (step) begin
      num_r  <= sbce_pkg::NUM_W'(full_num);
      on_r   <= now_r[3'(sbce_pkg::BYTE_W - 1) - ord];
      last_r <= (rest == '0);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.switch_number = num_r;
  assign out_ch.switch_on     = on_r;
  assign out_ch.last_event    = last_r;

  // a loaded byte always has at least one event
  a_load_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> busy)
    else $error("serializer loaded an unchanged byte");

  // without a new load, pending bits only ever clear
  a_mask_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !load) |=> ((mask_r & ~$past(mask_r)) == '0))
    else $error("pending bit appeared without a load");

  // the final event of a byte is flagged when its last bit is sent
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (step && ($countones(mask_r) == 1)) |=> (out_ch.valid && out_ch.last_event))
    else $error("final event not flagged");

endmodule

// ===== rtl/switch_bank_change_events.sv =====
// Switch bank change event detector.
// in_ch takes the bytes of a switch scan in scan order, first shifted switch
// in bit 7; last_in_scan marks the final byte and returns the byte position
// to zero (a scan longer than the bank wraps on its own).
// Each byte is compared with the byte stored for its position in the previous
// scan; for every changed bit out_ch gives one item with the switch number
// (position * 8 + bit order, bit 7 first), the new state and a last_event
// flag on the final event of that byte. A byte with no change gives no item.
// A changed byte passes the lookup stage, the serializer mask and the output
// register; an unchanged byte leaves the lookup stage without waiting. The
// serializer sends one event a cycle unless out_ch stalls, one per changed bit
// (up to 8); the next byte is looked up in the memory while it is busy.
// Reset (synchronous, rst_n low) clears the position, the pipeline and the
// per-entry written flags, so the previous scan reads as all switches open;
// no clearing pass is needed and items are accepted right after reset.
// A stalled receiver holds the output register; the serializer and then the
// lookup stage fill up and in_ch.ready drops, no event is lost.
module switch_bank_change_events (
  input  logic        clk,
  input  logic        rst_n,
  sbce_in_if.sink     in_ch,
  sbce_out_if.source  out_ch
);

  logic                chg_valid;
  logic                chg_ready;
  sbce_pkg::sbce_chg_t chg;

  // memory lookup and compare
  sbce_lookup u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .chg_valid(chg_valid),
    .chg_ready(chg_ready),
    .chg      (chg)
  );

  // event serializer and output register
  sbce_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .chg_valid(chg_valid),
    .chg_ready(chg_ready),
    .chg      (chg),
    .out_ch   (out_ch)
  );

endmodule
